// ===== src/cffd_pkg.sv =====
`default_nettype none
package cffd_pkg;

	localparam int DataBytesDefault = 32;
	localparam int QueueDepth = 4;

	localparam logic [15:0] CrcInit = 16'hffff;
	localparam logic [15:0] CrcPoly = 16'h8005;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_verdict;
		logic       crc_mismatch;
		logic       last;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/crc16_framed_flash_deframer.sv =====
// Accepts one item per cycle unless the queue is full; each result passes the queue and then the output register.
// Throughput is one item per cycle unless the queue is full; the front part's CRC byte update is combinational.
// A four-item queue lets the input keep flowing while the output is stalled, until the queue is full.
// Asynchronous active-low reset empties the queue and output and sets CRC mode on.
`default_nettype none
module crc16_framed_flash_deframer #(
	parameter int DATA_BYTES = cffd_pkg::DataBytesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // raw_byte[7:0], skip_bytes[12:8], read_length[36:13]
	input  wire logic        s_tuser,   // start_of_read
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // data_byte
	output      logic [1:0]  m_tuser,   // is_verdict[0], crc_mismatch[1]
	output      logic        m_tlast
);

	cffd_pkg::result_t push_data, head;
	logic push, full, empty, pop;

	cffd_front #(.DATA_BYTES(DATA_BYTES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.raw_byte     (s_tdata[7:0]),
		.start_of_read(s_tuser),
		.skip_bytes   (s_tdata[12:8]),
		.read_length  (s_tdata[36:13]),
		.q_full       (full),
		.q_push       (push),
		.q_data       (push_data)
	);

	cffd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	cffd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.q_head  (head),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
`default_nettype wire

// ===== src/cffd_front.sv =====
`default_nettype none
module cffd_front #(
	parameter int DATA_BYTES = cffd_pkg::DataBytesDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire logic [7:0]       raw_byte,
	input  wire logic             start_of_read,
	input  wire logic [4:0]       skip_bytes,
	input  wire logic [23:0]      read_length,
	input  wire logic             q_full,
	output      logic             q_push,
	output      cffd_pkg::result_t q_data
);

	localparam int PosW = $clog2(DATA_BYTES + 2);
	localparam logic [PosW-1:0] PosData = PosW'(DATA_BYTES);

	logic            crc_mode_q;
	logic [PosW-1:0] pos_q, pos_c, pos_n;
	logic [15:0]     crc_q, crc_c, crc_n;
	logic [7:0]      hi_q, hi_n;
	logic [23:0]     br_q, br_c, br_n;
	logic [4:0]      sk_q, sk_c, sk_n;
	logic            emit;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && emit;

	always_comb begin
		br_c  = start_of_read ? read_length : br_q;
		sk_c  = start_of_read ? skip_bytes : sk_q;
		pos_c = start_of_read ? '0 : pos_q;
		crc_c = start_of_read ? cffd_pkg::CrcInit : crc_q;
		br_n  = br_c;
		sk_n  = sk_c;
		pos_n = pos_c;
		crc_n = crc_c;
		hi_n  = hi_q;
		emit  = 1'b0;
		q_data = '{data_byte: raw_byte, is_verdict: 1'b0, crc_mismatch: 1'b0, last: 1'b0};
		if (!crc_mode_q) begin
			if (br_c != '0) begin
				br_n = br_c - 24'd1;
				emit = 1'b1;
				q_data.last = (br_n == '0);
			end
		end else if (br_c == '0 && pos_c == '0) begin
			emit = 1'b0;
		end else if (pos_c < PosData) begin
			crc_n = cffd_pkg::crc16_byte(crc_c, raw_byte);
			pos_n = pos_c + PosW'(1);
			if (sk_c != '0) begin
				sk_n = sk_c - 5'd1;
			end else if (br_c != '0) begin
				br_n = br_c - 24'd1;
				emit = 1'b1;
			end
		end else if (pos_c == PosData) begin
			hi_n  = raw_byte;
			pos_n = pos_c + PosW'(1);
		end else begin
			pos_n = '0;
			crc_n = cffd_pkg::CrcInit;
			sk_n  = '0;
			emit  = 1'b1;
			q_data.data_byte    = '0;
			q_data.is_verdict   = 1'b1;
			q_data.crc_mismatch = ({hi_q, raw_byte} != crc_c);
			q_data.last         = (br_c == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q <= 1'b1;
			pos_q      <= '0;
			crc_q      <= cffd_pkg::CrcInit;
			hi_q       <= '0;
			br_q       <= '0;
			sk_q       <= '0;
		end else begin
			if (cfg_we) begin
				crc_mode_q <= cfg_wdata;
			end
			if (accept) begin
				pos_q <= pos_n;
				crc_q <= crc_n;
				hi_q  <= hi_n;
				br_q  <= br_n;
				sk_q  <= sk_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/cffd_queue.sv =====
`default_nettype none
module cffd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cffd_pkg::result_t push_data,
	output      logic              full,
	output      logic              empty,
	input  wire logic              pop,
	output      cffd_pkg::result_t head
);

	localparam int PtrW = $clog2(cffd_pkg::QueueDepth);
	localparam int CntW = $clog2(cffd_pkg::QueueDepth + 1);

	cffd_pkg::result_t entry_q [cffd_pkg::QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full  = (cnt_q == CntW'(cffd_pkg::QueueDepth));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/cffd_back.sv =====
`default_nettype none
module cffd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire cffd_pkg::result_t q_head,
	output      logic              q_pop,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [7:0]        m_tdata,
	output      logic [1:0]        m_tuser,
	output      logic              m_tlast
);

	cffd_pkg::result_t out_q;
	logic              valid_q;

	assign q_pop    = !q_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = out_q.data_byte;
	assign m_tuser  = {out_q.crc_mismatch, out_q.is_verdict};
	assign m_tlast  = out_q.last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
